FILE: hdl/swrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrt_pkg
// Types and constants shared by the stop-and-wait retransmit timer.
// ----------------------------------------------------------------------------
package swrt_pkg;

    localparam int FRAG_W     = 16;
    localparam int TIME_W     = 32;
    localparam int TIMEOUT_W  = 35;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // largest fragment count the sender will honor, capped to the field width
    localparam int unsigned MAX_FRAGMENTS = 65535;
    localparam logic [FRAG_W-1:0] FRAG_CAP =
        (MAX_FRAGMENTS > 65535) ? 16'hFFFF :
        (MAX_FRAGMENTS < 1)     ? 16'd1    : FRAG_W'(MAX_FRAGMENTS);

    localparam logic [FRAG_W-1:0]    FRAG_TOTAL_RESET   = 16'd1;
    localparam logic [TIME_W-1:0]    INIT_TIMEOUT_RESET = 32'd1000000;

    // commands
    localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NAK     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAGMENT_TOTAL     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TIMEOUT_US = 1'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TIME_W-1:0] rtt_sample_us;
    } swrt_cmd_t;

    typedef struct packed {
        logic [FRAG_W-1:0]    fragment_number;
        logic                 is_resend;
        logic [TIMEOUT_W-1:0] timeout_us;
        logic                 transfer_done;
        logic                 ignored;
    } swrt_res_t;

endpackage

FILE: hdl/stop_wait_retransmit_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_wait_retransmit_timer
// Stop-and-wait sender control with an adaptive retransmission timeout.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel: one event per beat (start, ack with rtt sample, nak, timeout).
//   res channel: exactly one result beat per command beat, in order, giving
//   the fragment to send (0 for none), resend flag, current timeout, done and
//   ignored flags.
//   cfg port: fragment_total (index 0) and initial_timeout_us (index 1), to be
//   written only while no command is in flight.
//   A command accepted into the command register has its result registered
//   in the result register, which drives res_valid, once that can advance.
//   Throughput: one command per cycle while res_stall does not hold the result
//   register; the estimator update (shift-add smoothing of estimate and
//   deviation) is combinational between the command and result registers.
//   Reset: idle, no estimate, timeout 1000000 us, fragment_total 1.
//   When res_stall is high the result register holds; one more command can
//   sit in the command register, then cmd_stall is raised.
// ----------------------------------------------------------------------------
module stop_wait_retransmit_timer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [swrt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swrt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  swrt_pkg::swrt_cmd_t               cmd,
    output logic                              res_valid,
    input  logic                              res_stall,
    output swrt_pkg::swrt_res_t               res
);
    import swrt_pkg::*;

    // configuration
    logic [FRAG_W-1:0]    frag_total_reg;
    logic [TIME_W-1:0]    init_timeout_reg;

    // command register
    logic                 cmd_valid_reg;
    swrt_cmd_t            cmd_reg;

    // sender state
    logic                 running_reg,   running_next;
    logic                 finished_reg,  finished_next;
    logic                 resent_reg,    resent_next;
    logic [FRAG_W-1:0]    cur_frag_reg,  cur_frag_next;
    logic [TIME_W-1:0]    est_reg,       est_next;
    logic [TIME_W-1:0]    dev_reg,       dev_next;
    logic [TIMEOUT_W-1:0] timeout_reg,   timeout_next;

    // result register
    logic                 res_valid_reg;
    swrt_res_t            res_reg,       res_next;

    logic                 advance;
    logic                 consume;

    logic [FRAG_W-1:0]    eff_total;
    logic [TIME_W-1:0]    init_timeout;
    logic [TIME_W-1:0]    est_base;
    logic [TIMEOUT_W-1:0] est_sum;
    logic [TIME_W-1:0]    new_est;
    logic [TIME_W-1:0]    diff;
    logic [TIME_W+1:0]    dev_sum;
    logic [TIME_W-1:0]    new_dev;
    logic [TIMEOUT_W-1:0] new_timeout;

    assign advance   = !res_valid_reg || !res_stall;
    assign consume   = cmd_valid_reg && advance;
    assign cmd_stall = cmd_valid_reg && !advance;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frag_total_reg   <= FRAG_TOTAL_RESET;
            init_timeout_reg <= INIT_TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FRAGMENT_TOTAL:     frag_total_reg   <= cfg_data[FRAG_W-1:0];
                CFG_INITIAL_TIMEOUT_US: init_timeout_reg <= cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- estimator datapath ----
    always_comb
    begin
        if (frag_total_reg == '0)
            eff_total = FRAG_W'(1);
        else if (frag_total_reg > FRAG_CAP)
            eff_total = FRAG_CAP;
        else
            eff_total = frag_total_reg;

        init_timeout = (init_timeout_reg == '0) ? TIME_W'(1) : init_timeout_reg;

        // first fragment seeds the estimate with the sample
        est_base = (cur_frag_reg == FRAG_W'(1)) ? cmd_reg.rtt_sample_us : est_reg;
        est_sum  = ({3'b000, est_base} << 3) - {3'b000, est_base}
                   + {3'b000, cmd_reg.rtt_sample_us};
        new_est  = est_sum[TIMEOUT_W-1:3];

        diff = (cmd_reg.rtt_sample_us >= new_est) ? cmd_reg.rtt_sample_us - new_est
                                                  : new_est - cmd_reg.rtt_sample_us;
        dev_sum = ({2'b00, dev_reg} << 1) + {2'b00, dev_reg} + {2'b00, diff};
        new_dev = dev_sum[TIME_W+1:2];

        new_timeout = {3'b000, new_est} + ({3'b000, new_dev} << 2);
        if (new_timeout == '0)
            new_timeout = TIMEOUT_W'(1);
    end

    // ---- command decode and state update ----
    always_comb
    begin
        running_next  = running_reg;
        finished_next = finished_reg;
        resent_next   = resent_reg;
        cur_frag_next = cur_frag_reg;
        est_next      = est_reg;
        dev_next      = dev_reg;
        timeout_next  = timeout_reg;

        res_next.fragment_number = '0;
        res_next.is_resend       = 1'b0;
        res_next.ignored         = 1'b0;

        case (cmd_reg.command)
            CMD_START:
            begin
                if (running_reg)
                    res_next.ignored = 1'b1;
                else
                begin
                    running_next  = 1'b1;
                    finished_next = 1'b0;
                    cur_frag_next = FRAG_W'(1);
                    resent_next   = 1'b0;
                    est_next      = '0;
                    dev_next      = '0;
                    timeout_next  = {3'b000, init_timeout};
                    res_next.fragment_number = FRAG_W'(1);
                end
            end
            CMD_ACK:
            begin
                if (!running_reg)
                    res_next.ignored = 1'b1;
                else
                begin
                    // only fragments never resent feed the estimator
                    if (!resent_reg)
                    begin
                        est_next     = new_est;
                        dev_next     = new_dev;
                        timeout_next = new_timeout;
                    end
                    resent_next = 1'b0;
                    if (cur_frag_reg >= eff_total)
                    begin
                        running_next  = 1'b0;
                        finished_next = 1'b1;
                    end
                    else
                    begin
                        cur_frag_next = cur_frag_reg + FRAG_W'(1);
                        res_next.fragment_number = cur_frag_reg + FRAG_W'(1);
                    end
                end
            end
            CMD_NAK, CMD_TIMEOUT:
            begin
                if (!running_reg)
                    res_next.ignored = 1'b1;
                else
                begin
                    resent_next = 1'b1;
                    res_next.fragment_number = cur_frag_reg;
                    res_next.is_resend       = 1'b1;
                end
            end
            default:
                res_next.ignored = 1'b1;
        endcase

        res_next.timeout_us    = timeout_next;
        res_next.transfer_done = finished_next;
    end

    // ---- registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            running_reg   <= 1'b0;
            finished_reg  <= 1'b0;
            resent_reg    <= 1'b0;
            cur_frag_reg  <= '0;
            est_reg       <= '0;
            dev_reg       <= '0;
            timeout_reg   <= {3'b000, INIT_TIMEOUT_RESET};
        end
        else
        begin
            if (!cmd_stall)
                cmd_valid_reg <= cmd_valid;
            if (advance)
                res_valid_reg <= cmd_valid_reg;
            if (consume)
            begin
                running_reg  <= running_next;
                finished_reg <= finished_next;
                resent_reg   <= resent_next;
                cur_frag_reg <= cur_frag_next;
                est_reg      <= est_next;
                dev_reg      <= dev_next;
                timeout_reg  <= timeout_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
            cmd_reg <= cmd;
        if (consume)
            res_reg <= res_next;
    end

`ifndef SYNTHESIS
    a_run_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(running_reg && finished_reg))
        else $error("running and finished both set");

    a_run_frag: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (cur_frag_reg != '0))
        else $error("running with no current fragment");

    a_ignored_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.ignored) |->
            (res_reg.fragment_number == '0 && !res_reg.is_resend))
        else $error("ignored beat carries a fragment");

    a_timeout_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (timeout_reg != '0))
        else $error("retransmission timeout is zero");
`endif

endmodule

FILE: dv/swrt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrt_checker
// Watches the config port and both channels of the retransmit timer, keeps
// its own copy of the sender state and the smoothed rtt estimator, and
// compares every result beat against the oldest predicted result.
// ----------------------------------------------------------------------------
module swrt_checker
    import swrt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   cmd_valid,
    input  logic                   cmd_stall,
    input  swrt_cmd_t              cmd,
    input  logic                   res_valid,
    input  logic                   res_stall,
    input  swrt_res_t              res,
    output int                     errors,
    output int                     pending
);

    // programmed registers
    logic [FRAG_W-1:0]    frag_total_reg;
    logic [TIME_W-1:0]    init_rto_reg;

    // sender state
    logic                 sending;
    logic [FRAG_W-1:0]    frag_now;
    logic                 frag_resent;
    logic [TIME_W-1:0]    srtt;
    logic [TIME_W-1:0]    rttvar;
    logic [TIMEOUT_W-1:0] rto;
    logic                 xfer_done;

    swrt_res_t expected_results[$];
    int        fail_count;

    assign errors = fail_count;

    function automatic logic [TIMEOUT_W-1:0] start_rto();
        return (init_rto_reg == '0) ? TIMEOUT_W'(1) : TIMEOUT_W'(init_rto_reg);
    endfunction

    function automatic swrt_res_t step_sender(input swrt_cmd_t c);
        swrt_res_t            r;
        logic [FRAG_W-1:0]    last_frag;
        logic [35:0]          acc;
        logic [TIME_W-1:0]    err;
        logic [TIMEOUT_W-1:0] t;
        r = '0;
        last_frag = (frag_total_reg == '0) ? FRAG_W'(1) : frag_total_reg;
        if (last_frag > FRAG_CAP)
            last_frag = FRAG_CAP;
        if (c.command == CMD_START) begin
            if (sending) begin
                r.ignored = 1'b1;
            end
            else begin
                sending     = 1'b1;
                xfer_done   = 1'b0;
                frag_now    = FRAG_W'(1);
                frag_resent = 1'b0;
                srtt        = '0;
                rttvar      = '0;
                rto         = start_rto();
                r.fragment_number = FRAG_W'(1);
            end
        end
        else if (!sending) begin
            r.ignored = 1'b1;
        end
        else if (c.command == CMD_ACK) begin
            // karn: samples for retransmitted fragments are ambiguous
            if (!frag_resent) begin
                if (frag_now == FRAG_W'(1))
                    srtt = c.rtt_sample_us;
                acc  = 36'(srtt) * 7 + 36'(c.rtt_sample_us);
                srtt = TIME_W'(acc >> 3);
                err  = (c.rtt_sample_us >= srtt) ? c.rtt_sample_us - srtt
                                                 : srtt - c.rtt_sample_us;
                acc    = 36'(rttvar) * 3 + 36'(err);
                rttvar = TIME_W'(acc >> 2);
                t   = TIMEOUT_W'(srtt) + (TIMEOUT_W'(rttvar) << 2);
                rto = (t == '0) ? TIMEOUT_W'(1) : t;
            end
            frag_resent = 1'b0;
            if (frag_now >= last_frag) begin
                sending   = 1'b0;
                xfer_done = 1'b1;
            end
            else begin
                frag_now = frag_now + FRAG_W'(1);
                r.fragment_number = frag_now;
            end
        end
        else begin
            frag_resent       = 1'b1;
            r.fragment_number = frag_now;
            r.is_resend       = 1'b1;
        end
        r.timeout_us    = rto;
        r.transfer_done = xfer_done;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        swrt_res_t want;
        logic      bad;
        if (!rst_n) begin
            frag_total_reg = FRAG_TOTAL_RESET;
            init_rto_reg   = INIT_TIMEOUT_RESET;
            sending        = 1'b0;
            frag_now       = '0;
            frag_resent    = 1'b0;
            srtt           = '0;
            rttvar         = '0;
            rto            = start_rto();
            xfer_done      = 1'b0;
            expected_results.delete();
            fail_count     = 0;
            pending       <= 0;
        end
        else begin
            if (cfg_write === 1'b1) begin
                if (cfg_index == CFG_FRAGMENT_TOTAL)
                    frag_total_reg = cfg_data[FRAG_W-1:0];
                else if (cfg_index == CFG_INITIAL_TIMEOUT_US)
                    init_rto_reg = cfg_data[TIME_W-1:0];
            end
            // a result beat always trails its command, so it is checked before the new command is predicted
            if (res_valid === 1'b1 && res_stall === 1'b0) begin
                if (expected_results.size() == 0) begin
                    $display("%t: result beat with nothing expected, got %p", $time, res);
                    fail_count++;
                end
                else begin
                    want = expected_results.pop_front();
                    bad  = 1'b0;
                    if (res.fragment_number !== want.fragment_number) begin
                        $display("%t: fragment_number expected %0d got %0d",
                                 $time, want.fragment_number, res.fragment_number);
                        bad = 1'b1;
                    end
                    if (res.is_resend !== want.is_resend) begin
                        $display("%t: is_resend expected %0b got %0b",
                                 $time, want.is_resend, res.is_resend);
                        bad = 1'b1;
                    end
                    if (res.timeout_us !== want.timeout_us) begin
                        $display("%t: timeout_us expected %0d got %0d",
                                 $time, want.timeout_us, res.timeout_us);
                        bad = 1'b1;
                    end
                    if (res.transfer_done !== want.transfer_done) begin
                        $display("%t: transfer_done expected %0b got %0b",
                                 $time, want.transfer_done, res.transfer_done);
                        bad = 1'b1;
                    end
                    if (res.ignored !== want.ignored) begin
                        $display("%t: ignored expected %0b got %0b",
                                 $time, want.ignored, res.ignored);
                        bad = 1'b1;
                    end
                    if (bad)
                        fail_count++;
                end
            end
            if (cmd_valid === 1'b1 && cmd_stall === 1'b0)
                expected_results.push_back(step_sender(cmd));
            pending <= expected_results.size();
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the stop-and-wait retransmit timer: directed corner cases,
// then random transfers with naks, timeouts and noise under several register
// settings, with bursty command traffic and a stalling result receiver.
// ----------------------------------------------------------------------------
module tb;
    import swrt_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int RANDOM_BEATS = 1200;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  cmd_valid;
    logic                  cmd_stall;
    swrt_cmd_t             cmd;
    logic                  res_valid;
    logic                  res_stall;
    swrt_res_t             res;

    int errors;
    int pending;
    int idle_cycles = 0;
    int burst_left;
    int beats_sent;
    bit hold_req;

    always #2 clk = ~clk;

    stop_wait_retransmit_timer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    swrt_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .errors    (errors),
        .pending   (pending)
    );

    // no beat on either channel for too long means the block is stuck
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // result receiver
    initial
    begin : receiver
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        res_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: res_stall <= 1'b0;
                    1: res_stall <= ($urandom_range(0, 3) == 0);
                    2: res_stall <= ($urandom_range(0, 9) < 7);
                    default:
                        res_stall <= ($urandom_range(0, 15) == 0) ? ~res_stall : res_stall;
                endcase
            end
        end
    end

    task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [TIME_W-1:0] rtt);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
            if (gap != 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        cmd_valid <= 1'b1;
        cmd.command       <= op;
        cmd.rtt_sample_us <= rtt;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        burst_left--;
        beats_sent++;
    endtask

    // stop offering beats and wait for every expected result
    task automatic drain();
        cmd_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic program_regs(input bit do_total, input logic [CFG_DATA_W-1:0] total_word,
                                input bit do_init, input logic [CFG_DATA_W-1:0] init_word);
        if (do_total)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_FRAGMENT_TOTAL;
            cfg_data  <= total_word;
            @(posedge clk);
        end
        if (do_init)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_INITIAL_TIMEOUT_US;
            cfg_data  <= init_word;
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    function automatic logic [TIME_W-1:0] pick_rtt();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom;
            3: return $urandom_range(1000, 1000000);
            default: return $urandom_range(0, 3000);
        endcase
    endfunction

    initial
    begin : stimulus
        int                   budget;
        int                   n;
        int                   retries;
        int                   frag;
        int                   xfer_len;
        bit                   first_phase;
        logic [FRAG_W-1:0]    total;
        logic [CFG_DATA_W-1:0] init_word;
        int                   which;

        rst_n       = 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= CFG_FRAGMENT_TOTAL;
        cfg_data    <= '0;
        cmd_valid   <= 1'b0;
        cmd         <= '0;
        burst_left  = 0;
        beats_sent  = 0;
        hold_req    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // commands while idle are ignored and report the reset timeout
        send_cmd(CMD_ACK, 32'd500);
        send_cmd(CMD_NAK, $urandom);
        send_cmd(CMD_TIMEOUT, $urandom);

        // junk in the upper data bits, zero initial timeout raised to one
        drain();
        program_regs(1'b1, {16'hA5C3, 16'd3}, 1'b1, 32'd0);
        send_cmd(CMD_START, $urandom);
        send_cmd(CMD_START, $urandom);
        send_cmd(CMD_ACK, 32'd0);
        send_cmd(CMD_NAK, $urandom);
        send_cmd(CMD_TIMEOUT, $urandom);
        send_cmd(CMD_ACK, 32'd777);
        send_cmd(CMD_ACK, 32'hFFFF_FFFF);
        send_cmd(CMD_ACK, 32'd5);
        send_cmd(CMD_START, $urandom);

        // total of zero acts as one and ends the running transfer on the next ack
        drain();
        program_regs(1'b1, 32'hFFFF_0000, 1'b1, 32'hFFFF_FFFF);
        send_cmd(CMD_ACK, 32'hFFFF_FFFF);
        send_cmd(CMD_START, $urandom);
        send_cmd(CMD_ACK, 32'd0);

        // largest total, extreme samples swing the deviation
        drain();
        program_regs(1'b1, 32'd65535, 1'b1, 32'd1000000);
        send_cmd(CMD_START, $urandom);
        send_cmd(CMD_ACK, 32'hFFFF_FFFF);
        send_cmd(CMD_ACK, 32'd0);
        send_cmd(CMD_ACK, 32'hFFFF_FFFF);
        send_cmd(CMD_ACK, 32'd12345);

        // shrink the total below the current fragment mid-transfer
        drain();
        program_regs(1'b1, 32'd2, 1'b0, '0);
        send_cmd(CMD_ACK, 32'd1);

        first_phase = 1'b1;
        beats_sent  = 0;
        while (beats_sent < RANDOM_BEATS)
        begin
            drain();
            case ($urandom_range(0, 19))
                0:       total = '0;
                1:       total = '1;
                2:       total = FRAG_W'($urandom_range(0, 65535));
                default: total = FRAG_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 7))
                0:       init_word = '0;
                1:       init_word = '1;
                2, 3:    init_word = $urandom;
                default: init_word = $urandom_range(1, 5000);
            endcase
            which = $urandom_range(0, 3);
            program_regs(which != 2, {16'($urandom), total}, which != 1, init_word);
            xfer_len = (total == '0) ? 1 : int'(total);

            // long receiver hold while commands keep coming
            if (first_phase || $urandom_range(0, 9) == 0)
                hold_req = 1'b1;
            first_phase = 1'b0;

            budget = $urandom_range(30, 120);
            n = 0;
            while (n < budget)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_cmd(CMD_W'($urandom_range(0, 3)), $urandom);
                    n++;
                end
                else
                begin
                    send_cmd(CMD_START, $urandom);
                    n++;
                    frag = 1;
                    while (frag <= xfer_len && n < budget)
                    begin
                        retries = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
                        repeat (retries)
                        begin
                            send_cmd($urandom_range(0, 1) ? CMD_NAK : CMD_TIMEOUT, $urandom);
                            n++;
                        end
                        // broken sequence: abandon the transfer early
                        if ($urandom_range(0, 39) == 0)
                            break;
                        send_cmd(CMD_ACK, pick_rtt());
                        n++;
                        frag++;
                    end
                end
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
